### rtl/ptob_pkg.sv
// Shared types, constants and helpers of the price-time order book matcher.
package ptob_pkg;

    localparam int SIDE_DEPTH = 32;
    localparam int SLOTS      = 2 * SIDE_DEPTH;
    localparam int AW         = $clog2(SLOTS);
    localparam int CW         = $clog2(SIDE_DEPTH + 1);
    localparam int VW         = 37;

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_CANCEL = 2'd1;
    localparam logic [1:0] KIND_MATCH  = 2'd2;
    localparam logic [1:0] KIND_VOLUME = 2'd3;

    localparam logic [1:0] RES_TRADE  = 2'd0;
    localparam logic [1:0] RES_ACK    = 2'd1;
    localparam logic [1:0] RES_VOLUME = 2'd2;

    typedef struct packed {
        logic [31:0] price;
        logic [31:0] remaining;
        logic [47:0] arr_time;
        logic [15:0] ident;
        logic [31:0] sequence_no;
    } t_entry;

    localparam int EW = $bits(t_entry);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_ADD_RD,
        ST_ADD_CMP,
        ST_CAN_RD,
        ST_CAN_CMP,
        ST_REM_RD,
        ST_REM_WR,
        ST_MT_CHK,
        ST_MT_EVAL,
        ST_TRADE,
        ST_VOL_RD,
        ST_VOL_CMP,
        ST_ACK
    } t_state;

    function automatic logic [AW-1:0] slot_addr(input logic sd, input logic [CW-1:0] idx);
        logic [AW-1:0] base;
        base = sd ? AW'(SIDE_DEPTH) : '0;
        return AW'(idx) + base;
    endfunction

endpackage

### rtl/ptob_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ptob_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/price_time_order_book_matcher.sv
// Top level of the price-time priority order book matcher.
// Usage:
//   Slave channel (i_s_*): one request per transaction. tuser carries the kind
//   (add, cancel, match, volume query); tdata the order fields.
//   Master channel (o_m_*): results. tuser carries the result kind, tlast marks
//   the final result of a request. A match gives one trade per fill and then
//   an acknowledgement; every other request gives one result.
// Flow: one request at a time; o_s_tready is high only when
//   the engine is idle. All order slots sit in one RAM with registered reads,
//   so the sequencer visits each slot with a read state and then a state that
//   uses the data: add shifts the orders behind the new one, cancel scans
//   both sides and then shifts the orders behind the removed one, volume
//   scans that side, and match updates the front order in place on a partial
//   fill and shifts that side to remove a filled-out one.
// A request is accepted while the previous result still waits in the output
//   register; a stalled receiver holds the engine at its next result.
// Reset empties both sides and clears the sequence counter; the RAM needs no
//   clearing pass since only live slots are read.
module price_time_order_book_matcher (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // order_tag[15:0], side[16], is_market[17], price[49:18], quantity[81:50],
    // arrival_time[129:82], zero pad[135:130]
    input  logic [135:0] i_s_tdata,
    // kind[1:0]
    input  logic [1:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // ok[0], buyer_id[16:1], seller_id[32:17], fill_quantity[64:33],
    // deal_price[96:65], unfilled[128:97], volume[165:129], bid_top[197:166],
    // ask_top[229:198], zero pad[231:230]
    output logic [231:0] o_m_tdata,
    // result_kind[1:0]
    output logic [1:0]   o_m_tuser,
    output logic         o_m_tlast
);
    localparam int CW = ptob_pkg::CW;
    localparam int AW = ptob_pkg::AW;
    localparam int VW = ptob_pkg::VW;

    ptob_pkg::t_state r_state, n_state;

    logic [1:0]    r_kind, n_kind;
    logic [15:0]   r_id, n_id;
    logic          r_side, n_side;
    logic          r_mkt, n_mkt;
    logic [31:0]   r_price, n_price;
    logic [31:0]   r_rem, n_rem;
    logic [47:0]   r_time, n_time;
    logic          r_sd, n_sd;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_cnt_bid, n_cnt_bid;
    logic [CW-1:0] r_cnt_ask, n_cnt_ask;
    logic [31:0]   r_ins, n_ins;
    logic          r_found, n_found;
    logic          r_fsd, n_fsd;
    logic [CW-1:0] r_fidx, n_fidx;
    logic [31:0]   r_best_age, n_best_age;
    logic          r_ret_match, n_ret_match;
    logic [15:0]   r_tid, n_tid;
    logic [31:0]   r_tprice, n_tprice;
    logic [31:0]   r_fill, n_fill;
    logic [VW-1:0] r_vol, n_vol;
    logic          r_ack_ok, n_ack_ok;
    logic [1:0]    r_ack_kind, n_ack_kind;
    logic [31:0]   r_front_bid, r_front_ask;

    logic          r_ovalid, n_ovalid;
    logic [1:0]    r_okind, n_okind;
    logic          r_ok, n_ok;
    logic [15:0]   r_obuyer, n_obuyer;
    logic [15:0]   r_oseller, n_oseller;
    logic [31:0]   r_ofill, n_ofill;
    logic [31:0]   r_otprice, n_otprice;
    logic [31:0]   r_ounf, n_ounf;
    logic [VW-1:0] r_ovol, n_ovol;
    logic [31:0]   r_obid, n_obid;
    logic [31:0]   r_oask, n_oask;
    logic          r_olast, n_olast;

    logic                  we;
    logic [AW-1:0]         waddr, raddr;
    ptob_pkg::t_entry      wdata, rdata;
    logic [ptob_pkg::EW-1:0] rdata_raw;

    ptob_ram #(
        .WIDTH(ptob_pkg::EW),
        .DEPTH(ptob_pkg::SLOTS)
    ) u_slots (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata_raw)
    );
    assign rdata = ptob_pkg::t_entry'(rdata_raw);

    logic          out_free, accept;
    logic [CW-1:0] cnt_sd, cnt_opp, cnt_own;
    logic [31:0]   bid_now, ask_now;
    logic          keep, hit;
    logic [31:0]   fill, age;
    logic [VW:0]   vsum;
    ptob_pkg::t_entry new_entry;

    assign out_free   = !r_ovalid || i_m_tready;
    assign o_s_tready = (r_state == ptob_pkg::ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign cnt_sd     = r_sd ? r_cnt_ask : r_cnt_bid;
    assign cnt_opp    = r_side ? r_cnt_bid : r_cnt_ask;
    assign cnt_own    = r_side ? r_cnt_ask : r_cnt_bid;
    assign bid_now    = (r_cnt_bid != '0) ? r_front_bid : 32'd0;
    assign ask_now    = (r_cnt_ask != '0) ? r_front_ask : 32'hFFFF_FFFF;

    assign keep = (r_side ? (rdata.price < r_price) : (rdata.price > r_price)) ||
                  ((rdata.price == r_price) && (rdata.arr_time <= r_time));
    assign hit  = r_side ? (r_price <= rdata.price) : (r_price >= rdata.price);
    assign fill = (r_rem < rdata.remaining) ? r_rem : rdata.remaining;
    assign age  = r_ins - rdata.sequence_no;
    assign vsum = {1'b0, r_vol} + (VW+1)'(rdata.remaining);

    always_comb begin
        new_entry.price       = r_price;
        new_entry.remaining   = r_rem;
        new_entry.arr_time    = r_time;
        new_entry.ident       = r_id;
        new_entry.sequence_no = r_ins;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ptob_pkg::ST_IDLE;
            r_cnt_bid <= '0;
            r_cnt_ask <= '0;
            r_ins     <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt_bid <= n_cnt_bid;
            r_cnt_ask <= n_cnt_ask;
            r_ins     <= n_ins;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_id        <= n_id;
        r_side      <= n_side;
        r_mkt       <= n_mkt;
        r_price     <= n_price;
        r_rem       <= n_rem;
        r_time      <= n_time;
        r_sd        <= n_sd;
        r_idx       <= n_idx;
        r_found     <= n_found;
        r_fsd       <= n_fsd;
        r_fidx      <= n_fidx;
        r_best_age  <= n_best_age;
        r_ret_match <= n_ret_match;
        r_tid       <= n_tid;
        r_tprice    <= n_tprice;
        r_fill      <= n_fill;
        r_vol       <= n_vol;
        r_ack_ok    <= n_ack_ok;
        r_ack_kind  <= n_ack_kind;
        r_okind     <= n_okind;
        r_ok        <= n_ok;
        r_obuyer    <= n_obuyer;
        r_oseller   <= n_oseller;
        r_ofill     <= n_ofill;
        r_otprice   <= n_otprice;
        r_ounf      <= n_ounf;
        r_ovol      <= n_ovol;
        r_obid      <= n_obid;
        r_oask      <= n_oask;
        r_olast     <= n_olast;
        // shadow of each side's front price
        if (we && waddr == ptob_pkg::slot_addr(1'b0, '0)) begin
            r_front_bid <= wdata.price;
        end
        if (we && waddr == ptob_pkg::slot_addr(1'b1, '0)) begin
            r_front_ask <= wdata.price;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_id        = r_id;
        n_side      = r_side;
        n_mkt       = r_mkt;
        n_price     = r_price;
        n_rem       = r_rem;
        n_time      = r_time;
        n_sd        = r_sd;
        n_idx       = r_idx;
        n_cnt_bid   = r_cnt_bid;
        n_cnt_ask   = r_cnt_ask;
        n_ins       = r_ins;
        n_found     = r_found;
        n_fsd       = r_fsd;
        n_fidx      = r_fidx;
        n_best_age  = r_best_age;
        n_ret_match = r_ret_match;
        n_tid       = r_tid;
        n_tprice    = r_tprice;
        n_fill      = r_fill;
        n_vol       = r_vol;
        n_ack_ok    = r_ack_ok;
        n_ack_kind  = r_ack_kind;
        n_ovalid    = r_ovalid && !i_m_tready;
        n_okind     = r_okind;
        n_ok        = r_ok;
        n_obuyer    = r_obuyer;
        n_oseller   = r_oseller;
        n_ofill     = r_ofill;
        n_otprice   = r_otprice;
        n_ounf      = r_ounf;
        n_ovol      = r_ovol;
        n_obid      = r_obid;
        n_oask      = r_oask;
        n_olast     = r_olast;
        we          = 1'b0;
        waddr       = '0;
        wdata       = rdata;
        raddr       = '0;

        unique case (r_state)
            ptob_pkg::ST_IDLE: begin
                if (accept) begin
                    n_kind  = i_s_tuser;
                    n_id    = i_s_tdata[15:0];
                    n_side  = i_s_tdata[16];
                    n_mkt   = i_s_tdata[17];
                    n_price = i_s_tdata[49:18];
                    n_rem   = i_s_tdata[81:50];
                    n_time  = i_s_tdata[129:82];
                    n_state = ptob_pkg::ST_START;
                end
            end
            ptob_pkg::ST_START: begin
                n_ack_kind = ptob_pkg::RES_ACK;
                n_ack_ok   = 1'b1;
                n_vol      = '0;
                n_found    = 1'b0;
                n_best_age = '0;
                n_idx      = '0;
                n_sd       = r_side;
                unique case (r_kind)
                    ptob_pkg::KIND_ADD: begin
                        n_idx = cnt_own;
                        if (cnt_own >= CW'(ptob_pkg::SIDE_DEPTH)) begin
                            n_ack_ok = 1'b0;
                            n_state  = ptob_pkg::ST_ACK;
                        end else begin
                            n_state = ptob_pkg::ST_ADD_RD;
                        end
                    end
                    ptob_pkg::KIND_CANCEL: begin
                        n_sd    = 1'b0;
                        n_state = ptob_pkg::ST_CAN_RD;
                    end
                    ptob_pkg::KIND_MATCH: begin
                        n_state = ptob_pkg::ST_MT_CHK;
                    end
                    default: begin
                        n_ack_kind = ptob_pkg::RES_VOLUME;
                        n_state    = ptob_pkg::ST_VOL_RD;
                    end
                endcase
            end
            ptob_pkg::ST_ADD_RD: begin
                if (r_idx == '0) begin
                    we    = 1'b1;
                    waddr = ptob_pkg::slot_addr(r_sd, '0);
                    wdata = new_entry;
                    n_ins = r_ins + 32'd1;
                    if (r_sd) n_cnt_ask = r_cnt_ask + CW'(1);
                    else      n_cnt_bid = r_cnt_bid + CW'(1);
                    n_state = ptob_pkg::ST_ACK;
                end else begin
                    raddr   = ptob_pkg::slot_addr(r_sd, r_idx - CW'(1));
                    n_state = ptob_pkg::ST_ADD_CMP;
                end
            end
            ptob_pkg::ST_ADD_CMP: begin
                we    = 1'b1;
                waddr = ptob_pkg::slot_addr(r_sd, r_idx);
                if (keep) begin
                    wdata = new_entry;
                    n_ins = r_ins + 32'd1;
                    if (r_sd) n_cnt_ask = r_cnt_ask + CW'(1);
                    else      n_cnt_bid = r_cnt_bid + CW'(1);
                    n_state = ptob_pkg::ST_ACK;
                end else begin
                    wdata   = rdata;
                    n_idx   = r_idx - CW'(1);
                    n_state = ptob_pkg::ST_ADD_RD;
                end
            end
            ptob_pkg::ST_CAN_RD: begin
                if (r_idx < cnt_sd) begin
                    raddr   = ptob_pkg::slot_addr(r_sd, r_idx);
                    n_state = ptob_pkg::ST_CAN_CMP;
                end else if (!r_sd) begin
                    n_sd  = 1'b1;
                    n_idx = '0;
                end else if (r_found) begin
                    n_sd        = r_fsd;
                    n_idx       = r_fidx;
                    n_ret_match = 1'b0;
                    n_state     = ptob_pkg::ST_REM_RD;
                end else begin
                    n_ack_ok = 1'b0;
                    n_state  = ptob_pkg::ST_ACK;
                end
            end
            ptob_pkg::ST_CAN_CMP: begin
                if (rdata.ident == r_id && (!r_found || age > r_best_age)) begin
                    n_found    = 1'b1;
                    n_best_age = age;
                    n_fsd      = r_sd;
                    n_fidx     = r_idx;
                end
                n_idx   = r_idx + CW'(1);
                n_state = ptob_pkg::ST_CAN_RD;
            end
            ptob_pkg::ST_REM_RD: begin
                if (r_idx + CW'(1) < cnt_sd) begin
                    raddr   = ptob_pkg::slot_addr(r_sd, r_idx + CW'(1));
                    n_state = ptob_pkg::ST_REM_WR;
                end else begin
                    if (r_sd) n_cnt_ask = r_cnt_ask - CW'(1);
                    else      n_cnt_bid = r_cnt_bid - CW'(1);
                    n_state = r_ret_match ? ptob_pkg::ST_TRADE : ptob_pkg::ST_ACK;
                end
            end
            ptob_pkg::ST_REM_WR: begin
                we      = 1'b1;
                waddr   = ptob_pkg::slot_addr(r_sd, r_idx);
                wdata   = rdata;
                n_idx   = r_idx + CW'(1);
                n_state = ptob_pkg::ST_REM_RD;
            end
            ptob_pkg::ST_MT_CHK: begin
                if (cnt_opp != '0 && r_rem != '0) begin
                    raddr   = ptob_pkg::slot_addr(!r_side, '0);
                    n_state = ptob_pkg::ST_MT_EVAL;
                end else begin
                    n_state = ptob_pkg::ST_ACK;
                end
            end
            ptob_pkg::ST_MT_EVAL: begin
                if (!r_mkt && !hit) begin
                    n_state = ptob_pkg::ST_ACK;
                end else begin
                    n_rem    = r_rem - fill;
                    n_fill   = fill;
                    n_tid    = rdata.ident;
                    n_tprice = rdata.price;
                    if (rdata.remaining == fill) begin
                        n_sd        = !r_side;
                        n_idx       = '0;
                        n_ret_match = 1'b1;
                        n_state     = ptob_pkg::ST_REM_RD;
                    end else begin
                        we              = 1'b1;
                        waddr           = ptob_pkg::slot_addr(!r_side, '0);
                        wdata           = rdata;
                        wdata.remaining = rdata.remaining - fill;
                        n_state         = ptob_pkg::ST_TRADE;
                    end
                end
            end
            ptob_pkg::ST_TRADE: begin
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_okind   = ptob_pkg::RES_TRADE;
                    n_ok      = 1'b1;
                    n_obuyer  = r_side ? r_tid : r_id;
                    n_oseller = r_side ? r_id : r_tid;
                    n_ofill   = r_fill;
                    n_otprice = r_tprice;
                    n_ounf    = '0;
                    n_ovol    = '0;
                    n_obid    = bid_now;
                    n_oask    = ask_now;
                    n_olast   = 1'b0;
                    n_state   = ptob_pkg::ST_MT_CHK;
                end
            end
            ptob_pkg::ST_VOL_RD: begin
                if (r_idx < cnt_sd) begin
                    raddr   = ptob_pkg::slot_addr(r_sd, r_idx);
                    n_state = ptob_pkg::ST_VOL_CMP;
                end else begin
                    n_state = ptob_pkg::ST_ACK;
                end
            end
            ptob_pkg::ST_VOL_CMP: begin
                if (rdata.price == r_price) begin
                    n_vol = vsum[VW] ? '1 : vsum[VW-1:0];
                end
                n_idx   = r_idx + CW'(1);
                n_state = ptob_pkg::ST_VOL_RD;
            end
            ptob_pkg::ST_ACK: begin
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_okind   = r_ack_kind;
                    n_ok      = r_ack_ok;
                    n_obuyer  = '0;
                    n_oseller = '0;
                    n_ofill   = '0;
                    n_otprice = '0;
                    n_ounf    = (r_kind == ptob_pkg::KIND_MATCH) ? r_rem : 32'd0;
                    n_ovol    = r_vol;
                    n_obid    = bid_now;
                    n_oask    = ask_now;
                    n_olast   = 1'b1;
                    n_state   = ptob_pkg::ST_IDLE;
                end
            end
            default: n_state = ptob_pkg::ST_IDLE;
        endcase
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_okind;
    assign o_m_tlast  = r_olast;
    assign o_m_tdata  = {2'b00, r_oask, r_obid, r_ovol, r_ounf, r_otprice, r_ofill,
                         r_oseller, r_obuyer, r_ok};
endmodule

### rtl/ptob_checker.sv
// Port-level checks of the order book matcher, bound to the top level.
module ptob_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [231:0] o_m_tdata,
    input logic [1:0]   o_m_tuser,
    input logic         o_m_tlast
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("request taken while busy");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tuser != 2'd3)
        else $error("bad result kind");

    a_trade: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> o_m_tuser == ptob_pkg::RES_TRADE && o_m_tdata[0])
        else $error("non-final result is not a trade");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == ptob_pkg::RES_TRADE |-> !o_m_tlast)
        else $error("trade marked final");
endmodule

bind price_time_order_book_matcher ptob_checker u_ptob_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_s_tvalid(i_s_tvalid),
    .o_s_tready(o_s_tready),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata (o_m_tdata),
    .o_m_tuser (o_m_tuser),
    .o_m_tlast (o_m_tlast)
);
